### hdl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and field widths for the timer bank with task queue.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 3;
  localparam int TID_W    = 8;
  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 3'd0,
    KIND_ARM    = 3'd1,
    KIND_CANCEL = 3'd2,
    KIND_POST   = 3'd3,
    KIND_TAKE   = 3'd4
  } stb_kind_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] remaining;
    logic [PERIOD_W-1:0] reload;
    logic [TID_W-1:0]    tid;
  } stb_timer_t;

  typedef struct packed {
    logic               accepted;
    logic               task_valid;
    logic [TID_W-1:0]   task_out;
    logic [COUNT_W-1:0] posted_count;
    logic [COUNT_W-1:0] dropped_count;
  } stb_result_t;

endpackage

### hdl/stb_channels.sv
// ----------------------------------------------------------------------------
// stb_channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface stb_item_if
  import stb_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [INDEX_W-1:0]  timer_index;
  logic [TID_W-1:0]    task_id;
  logic [PERIOD_W-1:0] period;
  logic                one_shot;

  modport source (output valid, kind, timer_index, task_id, period, one_shot,
                  input ready);
  modport sink (input valid, kind, timer_index, task_id, period, one_shot,
                output ready);
endinterface

interface stb_result_if
  import stb_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               task_valid;
  logic [TID_W-1:0]   task_out;
  logic [COUNT_W-1:0] posted_count;
  logic [COUNT_W-1:0] dropped_count;

  modport source (output valid, accepted, task_valid, task_out, posted_count,
                  dropped_count, input ready);
  modport sink (input valid, accepted, task_valid, task_out, posted_count,
                dropped_count, output ready);
endinterface

### hdl/software_timer_bank_with_task_queue.sv
// ----------------------------------------------------------------------------
// software_timer_bank_with_task_queue
// Countdown timer bank that posts task ids into a ring queue.
//
//   channel  dir  payload                                       transfer
//   item     in   kind timer_index task_id period one_shot      valid & ready
//   result   out  accepted task_valid task_out posted dropped   valid & ready
//
// Arm, cancel, post and unknown kinds go from idle to done; take passes
// through a read state first if the queue is not empty. A tick does one
// timer memory read and write-back per cycle, pipelined one entry deep.
// rst is synchronous: timers disabled, queue empty, no result pending.
// A new item is taken while a finished result waits in the output register;
// the block stalls only when a second result is ready before the first leaves.
// ----------------------------------------------------------------------------
module software_timer_bank_with_task_queue
  import stb_pkg::*;
#(
  parameter int TIMER_COUNT   = 8,
  parameter int QUEUE_DEPTH   = 16,
  parameter int TASK_ID_WIDTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  stb_item_if.sink     item,
  stb_result_if.source result
);

  localparam int TW  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CW  = $clog2(TIMER_COUNT + 1);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int IDW = (TASK_ID_WIDTH < TID_W) ? TASK_ID_WIDTH : TID_W;

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_TAKE, S_DONE} state_t;

  function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] p);
    ring_next = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  stb_timer_t       tmem [TIMER_COUNT];
  logic [TID_W-1:0] qmem [QUEUE_DEPTH];

  state_t           state;
  logic [TIMER_COUNT-1:0] tmr_en;
  logic [TIMER_COUNT-1:0] tmr_single;
  logic [QW-1:0]    head;
  logic [QW-1:0]    tail;
  logic [CW-1:0]    rd_cnt;
  logic             wb_valid;
  logic [TW-1:0]    wb_idx;
  stb_result_t      res;
  stb_result_t      out_res;
  logic             out_valid;

  stb_timer_t       t_rd_data;
  logic [TID_W-1:0] q_rd_data;

  logic             accept;
  logic             idx_ok;
  logic [TW-1:0]    idx;
  logic [TID_W-1:0] id_m;
  logic [QW-1:0]    head_nx;
  logic             q_full;
  logic [TW-1:0]    t_rd_addr;

  logic             t_we;
  logic [TW-1:0]    t_wa;
  stb_timer_t       t_wd;
  logic             q_we;
  logic [TID_W-1:0] q_wd;

  logic [PERIOD_W-1:0] dec;
  logic             expire;
  logic             tick_push;
  logic             tick_drop;

  assign item.ready    = (state == S_IDLE);
  assign accept        = item.valid && item.ready;
  assign idx_ok        = int'(item.timer_index) < TIMER_COUNT;
  assign idx           = TW'(item.timer_index);
  assign id_m          = TID_W'(item.task_id[IDW-1:0]);
  assign head_nx       = ring_next(head);
  assign q_full        = (head_nx == tail);
  assign t_rd_addr     = (int'(rd_cnt) < TIMER_COUNT) ? TW'(rd_cnt) : '0;

  assign dec       = t_rd_data.remaining - 1'b1;
  assign expire    = (state == S_TICK) && wb_valid && tmr_en[wb_idx] && (dec == '0);
  assign tick_push = expire && (t_rd_data.tid != '0) && !q_full;
  assign tick_drop = expire && (t_rd_data.tid != '0) && q_full;

  always_comb begin
    t_we = 1'b0;
    t_wa = wb_idx;
    t_wd = t_rd_data;
    q_we = 1'b0;
    q_wd = id_m;
    if (state == S_TICK) begin
      if (wb_valid && tmr_en[wb_idx]) begin
        t_we = 1'b1;
        t_wd.remaining = (dec == '0) ? t_rd_data.reload : dec;
      end
      q_we = tick_push;
      q_wd = t_rd_data.tid;
    end else if (accept) begin
      if (item.kind == KIND_ARM && idx_ok) begin
        t_we = 1'b1;
        t_wa = idx;
        t_wd.remaining = item.period;
        t_wd.reload    = item.period;
        t_wd.tid       = id_m;
      end
      q_we = (item.kind == KIND_POST) && !q_full;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_wa] <= t_wd;
    end
    t_rd_data <= tmem[t_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[head_nx] <= q_wd;
    end
    q_rd_data <= qmem[ring_next(tail)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tmr_en     <= '0;
      tmr_single <= '0;
      head       <= '0;
      tail       <= '0;
      wb_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (q_we) begin
        head <= head_nx;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res.task_valid    <= 1'b0;
            res.task_out      <= '0;
            res.posted_count  <= '0;
            res.dropped_count <= '0;
            case (item.kind)
              KIND_TICK: begin
                res.accepted <= 1'b1;
                rd_cnt       <= '0;
                wb_valid     <= 1'b0;
                state        <= S_TICK;
              end
              KIND_ARM: begin
                res.accepted <= idx_ok;
                state        <= S_DONE;
                if (idx_ok) begin
                  tmr_en[idx]     <= 1'b1;
                  tmr_single[idx] <= item.one_shot;
                end
              end
              KIND_CANCEL: begin
                res.accepted <= idx_ok;
                state        <= S_DONE;
                if (idx_ok) begin
                  tmr_en[idx]     <= 1'b0;
                  tmr_single[idx] <= 1'b0;
                end
              end
              KIND_POST: begin
                res.accepted <= !q_full;
                state        <= S_DONE;
              end
              KIND_TAKE: begin
                res.accepted <= 1'b0;
                state        <= (head != tail) ? S_TAKE : S_DONE;
                if (head != tail) begin
                  tail <= ring_next(tail);
                end
              end
              default: begin
                res.accepted <= 1'b0;
                state        <= S_DONE;
              end
            endcase
          end
        end
        S_TICK: begin
          if (int'(rd_cnt) < TIMER_COUNT) begin
            rd_cnt   <= rd_cnt + 1'b1;
            wb_valid <= 1'b1;
            wb_idx   <= TW'(rd_cnt);
          end else begin
            wb_valid <= 1'b0;
            if (!wb_valid) begin
              state <= S_DONE;
            end
          end
          if (expire && tmr_single[wb_idx]) begin
            tmr_en[wb_idx]     <= 1'b0;
            tmr_single[wb_idx] <= 1'b0;
          end
          if (tick_push && res.posted_count != '1) begin
            res.posted_count <= res.posted_count + 1'b1;
          end
          if (tick_drop && res.dropped_count != '1) begin
            res.dropped_count <= res.dropped_count + 1'b1;
          end
        end
        S_TAKE: begin
          res.accepted   <= 1'b1;
          res.task_valid <= 1'b1;
          res.task_out   <= q_rd_data;
          state          <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_res <= res;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.accepted      = out_res.accepted;
  assign result.task_valid    = out_res.task_valid;
  assign result.task_out      = out_res.task_out;
  assign result.posted_count  = out_res.posted_count;
  assign result.dropped_count = out_res.dropped_count;

endmodule
